// ===== sv/atr_pkg.sv =====
// ----------------------------------------------------------------------------
// atr_pkg
// Shared widths, default timing values and TA1 decode tables for the ATR
// parser and its divider.
// ----------------------------------------------------------------------------
package atr_pkg;

	localparam int FI_W = 12;
	localparam int DI_W = 8;
	localparam int FMAX_W = 8;
	localparam int RAW_AFTER_BAD_TS = 8;
	localparam int RAW_CNT_W = 4;

	localparam logic [FI_W-1:0]   FI_DEFAULT   = 12'd372;
	localparam logic [DI_W-1:0]   DI_DEFAULT   = 8'd1;
	localparam logic [FMAX_W-1:0] FMAX_DEFAULT = 8'd5;
	localparam logic [FI_W-1:0]   ETU_DEFAULT  = 12'd372;

	localparam logic [7:0] TS_INVERSE_RAW = 8'h03;
	localparam logic [7:0] TS_INVERSE_REP = 8'h3F;
	localparam logic [7:0] TS_DIRECT      = 8'h3B;

	typedef enum logic [2:0] {
		KIND_SKIP  = 3'd0,
		KIND_TS    = 3'd1,
		KIND_T0    = 3'd2,
		KIND_IFACE = 3'd3,
		KIND_HIST  = 3'd4,
		KIND_TCK   = 3'd5,
		KIND_RAW   = 3'd6,
		KIND_EXTRA = 3'd7
	} kind_t;

	function automatic logic [FI_W-1:0] fi_lookup(input logic [3:0] code);
		logic [FI_W-1:0] v;
		case (code)
			4'd0, 4'd1: v = 12'd372;
			4'd2:       v = 12'd558;
			4'd3:       v = 12'd744;
			4'd4:       v = 12'd1116;
			4'd5:       v = 12'd1488;
			4'd6:       v = 12'd1860;
			4'd9:       v = 12'd512;
			4'd10:      v = 12'd768;
			4'd11:      v = 12'd1024;
			4'd12:      v = 12'd1536;
			4'd13:      v = 12'd2048;
			default:    v = 12'd255;
		endcase
		return v;
	endfunction

	function automatic logic [DI_W-1:0] di_lookup(input logic [3:0] code);
		logic [DI_W-1:0] v;
		case (code)
			4'd1:    v = 8'd1;
			4'd2:    v = 8'd2;
			4'd3:    v = 8'd4;
			4'd4:    v = 8'd8;
			4'd5:    v = 8'd16;
			4'd6:    v = 8'd32;
			4'd7:    v = 8'd64;
			4'd8:    v = 8'd12;
			4'd9:    v = 8'd20;
			default: v = 8'd255;
		endcase
		return v;
	endfunction

	function automatic logic [FMAX_W-1:0] fmax_lookup(input logic [3:0] code);
		logic [FMAX_W-1:0] v;
		case (code)
			4'd0:       v = 8'd4;
			4'd1, 4'd9: v = 8'd5;
			4'd2:       v = 8'd6;
			4'd3:       v = 8'd8;
			4'd4:       v = 8'd12;
			4'd5:       v = 8'd16;
			4'd6, 4'd13: v = 8'd20;
			4'd10:      v = 8'd7;
			4'd11:      v = 8'd10;
			4'd12:      v = 8'd15;
			default:    v = 8'd255;
		endcase
		return v;
	endfunction

endpackage

// ===== sv/atr_div.sv =====
// ----------------------------------------------------------------------------
// atr_div
// Restoring divider, one quotient bit per cycle. Computes Fi / Di for the
// elementary time unit. Divisor is never zero.
// ----------------------------------------------------------------------------
module atr_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [atr_pkg::FI_W-1:0]    dividend,
	input  logic [atr_pkg::DI_W-1:0]    divisor,
	output logic                        done,
	output logic [atr_pkg::FI_W-1:0]    quotient
);

	localparam int CNT_W = $clog2(atr_pkg::FI_W + 1);

	logic [atr_pkg::FI_W-1:0] quo_q;
	logic [atr_pkg::DI_W-1:0] rem_q;
	logic [atr_pkg::DI_W-1:0] div_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     done_q;

	logic [atr_pkg::DI_W:0]   shifted;
	logic [atr_pkg::DI_W+1:0] trial;

	// partial remainder with next dividend bit shifted in, then trial subtract
	assign shifted = {rem_q, quo_q[atr_pkg::FI_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(atr_pkg::FI_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!trial[atr_pkg::DI_W+1]) begin
				rem_q <= trial[atr_pkg::DI_W-1:0];
				quo_q <= {quo_q[atr_pkg::FI_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[atr_pkg::DI_W-1:0];
				quo_q <= {quo_q[atr_pkg::FI_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== sv/smartcard_atr_parser.sv =====
// ----------------------------------------------------------------------------
// smartcard_atr_parser
// Classifies received answer-to-reset bytes and tracks TA1 timing.
// ----------------------------------------------------------------------------
// Input stream: one raw card byte per word on s_tdata, s_tuser high marks the
// TS position of a new ATR and restarts parsing.
// Output stream: one word per input word, carrying the converted byte, its
// kind, the convention, bad-TS and TCK flags, and the current Fi, Di, ETU and fMax.
// m_tlast marks the final byte of the ATR or of the raw run after a bad TS.
// Path: an ordinary byte is registered with its kind and last flag when taken,
// then moves to the output register. A TA1 byte waits first in ST_DIV: the ETU
// is Fi / Di from a restoring divider that produces one quotient bit per cycle.
// s_tready is high only while the sequencer is idle, so one byte is in work
// at a time; a finished word can wait in the output register while the next
// byte is taken in.
// Reset: parser waits for TS, direct convention, timing 372 / 1 / 5 / 372,
// no output word pending.
// Receiver stall: the word holds on the output and the next result waits in
// the sequencer until the output register frees up.
// ----------------------------------------------------------------------------
module smartcard_atr_parser #(
	parameter int RAW_AFTER_BAD_TS = atr_pkg::RAW_AFTER_BAD_TS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] new_atr
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] data_byte, [19:8] fi_value, [27:20] di_value,
	// [39:28] etu_cycles, [47:40] fmax_mhz
	output logic [47:0] m_tdata,
	// [2:0] byte_kind, [3] inverse_mode, [4] bad_ts, [5] tck_expected
	output logic [5:0]  m_tuser,
	output logic        m_tlast    // last
);

	localparam logic [atr_pkg::RAW_CNT_W-1:0] RawLen =
		atr_pkg::RAW_CNT_W'(RAW_AFTER_BAD_TS);

	typedef enum logic [2:0] {
		PH_TS, PH_T0, PH_IFACE, PH_HIST, PH_TCK, PH_RAW, PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE, ST_DIV, ST_PUSH
	} seq_t;

	function automatic logic [7:0] inv_conv(input logic [7:0] b);
		logic [7:0] r;
		for (int i = 0; i < 8; i++)
			r[7-i] = ~b[i];
		return r;
	endfunction

	// parser state
	seq_t                              st_q;
	phase_t                            phase_q;
	logic                              inv_q, zskip_q, first_q, tck_q, bad_q;
	logic [3:0]                        pend_q, hist_q;
	logic [atr_pkg::RAW_CNT_W-1:0]     raw_q;
	logic [atr_pkg::FI_W-1:0]          fi_q, etu_q;
	logic [atr_pkg::DI_W-1:0]          di_q;
	logic [atr_pkg::FMAX_W-1:0]        fmax_q;
	logic [7:0]                        data_q;
	atr_pkg::kind_t                    kind_q;
	logic                              last_q;

	// output register
	logic                              m_tvalid_q;
	logic [47:0]                       m_tdata_q;
	logic [5:0]                        m_tuser_q;
	logic                              m_tlast_q;

	// next-state of one parse step
	phase_t                            ph_n;
	logic                              inv_n, zskip_n, first_n, tck_n, bad_n;
	logic [3:0]                        pend_n, hist_n, bit_n;
	logic [atr_pkg::RAW_CNT_W-1:0]     raw_n;
	logic [7:0]                        data_n;
	atr_pkg::kind_t                    kind_n;
	logic                              last_n, def_n, ta1_n;

	logic                              accept, out_free, div_done;
	logic [atr_pkg::FI_W-1:0]          div_quo;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (st_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		ph_n    = phase_q;
		inv_n   = inv_q;
		zskip_n = zskip_q;
		first_n = first_q;
		tck_n   = tck_q;
		bad_n   = bad_q;
		pend_n  = pend_q;
		hist_n  = hist_q;
		raw_n   = raw_q;
		def_n   = 1'b0;
		ta1_n   = 1'b0;
		data_n  = 8'h00;
		kind_n  = atr_pkg::KIND_EXTRA;
		last_n  = 1'b0;
		bit_n   = 4'h0;

		if (s_tuser) begin
			ph_n    = PH_TS;
			inv_n   = 1'b0;
			zskip_n = 1'b0;
			first_n = 1'b0;
			tck_n   = 1'b0;
			bad_n   = 1'b0;
			pend_n  = 4'h0;
			hist_n  = 4'h0;
			raw_n   = '0;
			def_n   = 1'b1;
		end

		case (ph_n)
			PH_TS: begin
				if (s_tdata == 8'h00 && !zskip_n) begin
					zskip_n = 1'b1;
					kind_n  = atr_pkg::KIND_SKIP;
				end else begin
					kind_n = atr_pkg::KIND_TS;
					if (s_tdata == atr_pkg::TS_INVERSE_RAW) begin
						inv_n  = 1'b1;
						data_n = atr_pkg::TS_INVERSE_REP;
						ph_n   = PH_T0;
					end else if (s_tdata == atr_pkg::TS_DIRECT) begin
						inv_n  = 1'b0;
						data_n = s_tdata;
						ph_n   = PH_T0;
					end else begin
						bad_n  = 1'b1;
						data_n = s_tdata;
						raw_n  = RawLen;
						ph_n   = (RawLen != '0) ? PH_RAW : PH_DONE;
						last_n = (RawLen == '0);
					end
				end
			end
			PH_RAW: begin
				kind_n = atr_pkg::KIND_RAW;
				data_n = s_tdata;
				raw_n  = raw_n - 1'b1;
				if (raw_n == '0) begin
					ph_n   = PH_DONE;
					last_n = 1'b1;
				end
			end
			PH_T0: begin
				data_n  = inv_n ? inv_conv(s_tdata) : s_tdata;
				kind_n  = atr_pkg::KIND_T0;
				pend_n  = data_n[7:4];
				hist_n  = data_n[3:0];
				first_n = 1'b0;
				if (!data_n[4])
					def_n = 1'b1;
				if (pend_n != 4'h0)
					ph_n = PH_IFACE;
				else if (hist_n != 4'h0)
					ph_n = PH_HIST;
				else
					ph_n = tck_n ? PH_TCK : PH_DONE;
				last_n = (ph_n == PH_DONE);
			end
			PH_IFACE: begin
				data_n = inv_n ? inv_conv(s_tdata) : s_tdata;
				kind_n = atr_pkg::KIND_IFACE;
				// lowest pending presence bit names this byte: TA, TB, TC, TD
				bit_n  = pend_n & (~pend_n + 4'h1);
				if (!first_n && bit_n == 4'b0001)
					ta1_n = 1'b1;
				first_n = 1'b1;
				pend_n  = pend_n & ~bit_n;
				if (bit_n == 4'b1000) begin
					if (data_n[3:0] != 4'h0)
						tck_n = 1'b1;
					pend_n = data_n[7:4];
				end
				if (pend_n == 4'h0) begin
					if (hist_n != 4'h0)
						ph_n = PH_HIST;
					else
						ph_n = tck_n ? PH_TCK : PH_DONE;
				end
				last_n = (ph_n == PH_DONE);
			end
			PH_HIST: begin
				data_n = inv_n ? inv_conv(s_tdata) : s_tdata;
				kind_n = atr_pkg::KIND_HIST;
				hist_n = hist_n - 4'h1;
				if (hist_n == 4'h0) begin
					ph_n   = tck_n ? PH_TCK : PH_DONE;
					last_n = (ph_n == PH_DONE);
				end
			end
			PH_TCK: begin
				data_n = inv_n ? inv_conv(s_tdata) : s_tdata;
				kind_n = atr_pkg::KIND_TCK;
				ph_n   = PH_DONE;
				last_n = 1'b1;
			end
			default: begin
				data_n = inv_n ? inv_conv(s_tdata) : s_tdata;
				kind_n = atr_pkg::KIND_EXTRA;
			end
		endcase
	end

	atr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && ta1_n),
		.dividend (atr_pkg::fi_lookup(data_n[7:4])),
		.divisor  (atr_pkg::di_lookup(data_n[3:0])),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			phase_q    <= PH_TS;
			inv_q      <= 1'b0;
			zskip_q    <= 1'b0;
			first_q    <= 1'b0;
			tck_q      <= 1'b0;
			bad_q      <= 1'b0;
			pend_q     <= 4'h0;
			hist_q     <= 4'h0;
			raw_q      <= '0;
			fi_q       <= atr_pkg::FI_DEFAULT;
			di_q       <= atr_pkg::DI_DEFAULT;
			fmax_q     <= atr_pkg::FMAX_DEFAULT;
			etu_q      <= atr_pkg::ETU_DEFAULT;
			m_tvalid_q <= 1'b0;
		end else begin
			if (st_q == ST_PUSH && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						phase_q <= ph_n;
						inv_q   <= inv_n;
						zskip_q <= zskip_n;
						first_q <= first_n;
						tck_q   <= tck_n;
						bad_q   <= bad_n;
						pend_q  <= pend_n;
						hist_q  <= hist_n;
						raw_q   <= raw_n;
						if (ta1_n) begin
							fi_q   <= atr_pkg::fi_lookup(data_n[7:4]);
							di_q   <= atr_pkg::di_lookup(data_n[3:0]);
							fmax_q <= atr_pkg::fmax_lookup(data_n[7:4]);
							st_q   <= ST_DIV;
						end else begin
							if (def_n) begin
								fi_q   <= atr_pkg::FI_DEFAULT;
								di_q   <= atr_pkg::DI_DEFAULT;
								fmax_q <= atr_pkg::FMAX_DEFAULT;
								etu_q  <= atr_pkg::ETU_DEFAULT;
							end
							st_q <= ST_PUSH;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						etu_q <= div_quo;
						st_q  <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (out_free)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= data_n;
			kind_q <= kind_n;
			last_q <= last_n;
		end
		if (st_q == ST_PUSH && out_free) begin
			m_tdata_q <= {fmax_q, etu_q, di_q, fi_q, data_q};
			m_tuser_q <= {tck_q, bad_q, inv_q, kind_q};
			m_tlast_q <= last_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule
